// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL of the operand shifter block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/idos_pkg.sv =====
// ----------------------------------------------------------------------------
// idos_pkg
// Types and constants shared by the instruction decode and operand shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package idos_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegW  = 4;
  localparam int unsigned AmtW  = 8;

  // Instruction classes as reported on the result stream.
  typedef enum logic [2:0] {
    KIND_BRANCH   = 3'd0,
    KIND_TRANSFER = 3'd1,
    KIND_MULTIPLY = 3'd2,
    KIND_DATA     = 3'd3,
    KIND_HALT     = 3'd4,
    KIND_UNDEF    = 3'd5
  } kind_t;

  // Class codes found in instruction bits 27..26.
  localparam logic [1:0] TOP_ZERO     = 2'd0;
  localparam logic [1:0] TOP_TRANSFER = 2'd1;
  localparam logic [1:0] TOP_BRANCH   = 2'd2;

  // Multiply signature in bits 7..4.
  localparam logic [3:0] MUL_SIG = 4'd9;

  // Shift types in bits 6..5.
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  // Decode fields handed from the decoder to the result register.
  typedef struct packed {
    kind_t             kind;
    logic              regs_valid;
    logic [RegW-1:0]   dest_reg;
    logic [RegW-1:0]   first_reg;
    logic [RegW-1:0]   second_reg;
    logic [RegW-1:0]   shift_reg;
    logic [WordW-1:0]  offset;
  } dec_t;

  // Barrel shifter outcome.
  typedef struct packed {
    logic [WordW-1:0] value;
    logic             carry;
  } shift_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/idos_decode.sv =====
// ----------------------------------------------------------------------------
// idos_decode
// Classifies an instruction word and extracts its register numbers and offset.
// ----------------------------------------------------------------------------
`default_nettype none

module idos_decode
  import idos_pkg::*;
(
  input  wire logic [WordW-1:0] instruction,
  output dec_t                  dec
);

  logic [1:0]       top;
  logic             is_mul;
  kind_t            kind;
  logic [2*WordW-1:0] imm_pair;
  logic [4:0]       imm_rot;

  // Class selection from bits 27..26, with multiply and halt under class zero.
  assign top    = instruction[27:26];
  assign is_mul = (instruction[7:4] == MUL_SIG) && (instruction[27:22] == 6'd0);

  always_comb begin
    case (top)
      TOP_BRANCH:   kind = KIND_BRANCH;
      TOP_TRANSFER: kind = KIND_TRANSFER;
      TOP_ZERO: begin
        if (is_mul) begin
          kind = KIND_MULTIPLY;
        end else if (instruction == '0) begin
          kind = KIND_HALT;
        end else begin
          kind = KIND_DATA;
        end
      end
      default:      kind = KIND_UNDEF;
    endcase
  end

  // The data immediate is the low byte rotated right by twice bits 11..8.
  assign imm_pair = {24'd0, instruction[7:0], 24'd0, instruction[7:0]};
  assign imm_rot  = {instruction[11:8], 1'b0};

  always_comb begin
    logic [2*WordW-1:0] rot_full;
    rot_full           = imm_pair >> imm_rot;
    dec.kind           = kind;
    dec.regs_valid     = 1'b0;
    dec.dest_reg       = '0;
    dec.first_reg      = '0;
    dec.second_reg     = instruction[3:0];
    dec.shift_reg      = instruction[11:8];
    dec.offset         = '0;
    case (kind)
      KIND_DATA: begin
        dec.regs_valid = 1'b1;
        dec.dest_reg   = instruction[15:12];
        dec.first_reg  = instruction[19:16];
        dec.offset     = rot_full[WordW-1:0];
      end
      KIND_TRANSFER: begin
        dec.regs_valid = 1'b1;
        dec.dest_reg   = instruction[15:12];
        dec.first_reg  = instruction[19:16];
        dec.offset     = {20'd0, instruction[11:0]};
      end
      KIND_MULTIPLY: begin
        dec.regs_valid = 1'b1;
        dec.dest_reg   = instruction[19:16];
        dec.first_reg  = instruction[15:12];
      end
      KIND_BRANCH: begin
        dec.offset     = {8'd0, instruction[23:0]};
      end
      default: begin
        dec.offset     = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/idos_shifter.sv =====
// ----------------------------------------------------------------------------
// idos_shifter
// Barrel shifter for the second operand with carry out of the last bit moved.
// ----------------------------------------------------------------------------
`default_nettype none

module idos_shifter
  import idos_pkg::*;
(
  input  wire logic [WordW-1:0] instruction,
  input  wire logic [WordW-1:0] rm_value,
  input  wire logic [WordW-1:0] rs_value,
  output shift_res_t            res
);

  logic [AmtW-1:0]      amt;
  shift_kind_t          sh_kind;
  logic [WordW:0]       lsl_t;
  logic [WordW:0]       lsr_t;
  logic signed [WordW:0] asr_t;
  logic [2*WordW-1:0]   ror_t;

  // Amount comes from the Rs low byte or the five-bit immediate field.
  assign amt     = instruction[4] ? rs_value[AmtW-1:0] : {3'd0, instruction[11:7]};
  assign sh_kind = shift_kind_t'(instruction[6:5]);

  // The LSL, LSR and ASR forms each carry one guard bit that ends up holding the last bit out.
  assign lsl_t = {1'b0, rm_value} << amt;
  assign lsr_t = {rm_value, 1'b0} >> amt;
  assign asr_t = $signed({rm_value, 1'b0}) >>> amt;
  assign ror_t = {rm_value, rm_value} >> amt[4:0];

  always_comb begin
    case (sh_kind)
      SH_LSL: begin
        res.value = lsl_t[WordW-1:0];
        res.carry = lsl_t[WordW];
      end
      SH_LSR: begin
        res.value = lsr_t[WordW:1];
        res.carry = lsr_t[0];
      end
      SH_ASR: begin
        res.value = asr_t[WordW:1];
        res.carry = asr_t[0];
      end
      default: begin
        // After rotating right, bit 31 holds the last bit that came around.
        res.value = ror_t[WordW-1:0];
        res.carry = (amt != '0) & ror_t[WordW-1];
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/instruction_decode_operand_shifter.sv =====
// ----------------------------------------------------------------------------
// instruction_decode_operand_shifter
// Decodes one instruction word and shifts its second operand per request.
// ----------------------------------------------------------------------------
// Each request carries an instruction word with the Rm and Rs register values
// and yields one result: the class, register numbers, class offset and the
// barrel-shifted Rm with its carry. A request passes through the input register
// and then the result register, and a new request is taken every cycle; the
// input side stalls only when both registers are full and the result is not
// being taken.
`default_nettype none

`include "assert_macros.svh"

module instruction_decode_operand_shifter
  import idos_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] instruction, [63:32] rm_value, [95:64] rs_value
  input  wire logic [95:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] inst_kind, [3] regs_valid, [7:4] dest_reg, [11:8] first_reg,
  // [15:12] second_reg, [19:16] shift_reg, [51:20] offset,
  // [83:52] shifted_operand, [84] shifter_carry, [87:85] zero
  output logic [87:0]      m_axis_tdata
);

  logic             s1_valid;
  logic [WordW-1:0] s1_instruction;
  logic [WordW-1:0] s1_rm;
  logic [WordW-1:0] s1_rs;
  logic             out_free;
  logic             s1_free;
  dec_t             dec;
  shift_res_t       sh;
  dec_t             r_dec;
  shift_res_t       r_sh;

  // Each register moves on when the stage after it is empty or draining.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_free       = !s1_valid || out_free;
  assign s_axis_tready = s1_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && s_axis_tvalid) begin
      s1_instruction <= s_axis_tdata[31:0];
      s1_rm          <= s_axis_tdata[63:32];
      s1_rs          <= s_axis_tdata[95:64];
    end
  end

  idos_decode u_decode (
    .instruction (s1_instruction),
    .dec         (dec)
  );

  idos_shifter u_shifter (
    .instruction (s1_instruction),
    .rm_value    (s1_rm),
    .rs_value    (s1_rs),
    .res         (sh)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      r_dec <= dec;
      r_sh  <= sh;
    end
  end

  assign m_axis_tdata = {3'd0, r_sh.carry, r_sh.value, r_dec.offset, r_dec.shift_reg,
                         r_dec.second_reg, r_dec.first_reg, r_dec.dest_reg,
                         r_dec.regs_valid, r_dec.kind};

  // A held input request must not be lost while the output is stalled.
  `ASSERT_NEXT(a_hold_s1, clk, rst, s1_valid && m_axis_tvalid && !m_axis_tready, s1_valid, "input stage dropped a request during stall")

  // With an empty output register the block always takes a request.
  `ASSERT_IMPLIES(a_ready_free, clk, rst, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // Register numbers are only reported for classes that have them.
  `ASSERT_IMPLIES(a_regs_kind, clk, rst, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[2:0] == KIND_TRANSFER || m_axis_tdata[2:0] == KIND_DATA || m_axis_tdata[2:0] == KIND_MULTIPLY, "register flag set for a class without registers")

  // Classes without an offset report zero.
  `ASSERT_IMPLIES(a_no_offset, clk, rst, m_axis_tvalid && (m_axis_tdata[2:0] == KIND_HALT || m_axis_tdata[2:0] == KIND_UNDEF || m_axis_tdata[2:0] == KIND_MULTIPLY), m_axis_tdata[51:20] == '0, "nonzero offset for a class without one")

endmodule

`default_nettype wire
